### hdl/ladder_key_decode_debounce_macros.svh
`ifndef LADDER_KEY_DECODE_DEBOUNCE_MACROS_SVH
`define LADDER_KEY_DECODE_DEBOUNCE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define LADK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle leads to a consequence in the next.
`define LADK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/ladk_pkg.sv
package ladk_pkg;

    localparam int THR_BITS        = 12;
    localparam int CNT_BITS        = 4;
    localparam int KEY_BITS        = 3;
    localparam int EV_BITS         = 2;
    localparam int CFG_ADDR_BITS   = 3;
    localparam int SAMPLE_BITS_DEF = 12;

    localparam logic [KEY_BITS-1:0] KEY_NONE   = 3'd0;
    localparam logic [KEY_BITS-1:0] KEY_UP     = 3'd1;
    localparam logic [KEY_BITS-1:0] KEY_LEFT   = 3'd2;
    localparam logic [KEY_BITS-1:0] KEY_CENTER = 3'd3;
    localparam logic [KEY_BITS-1:0] KEY_RIGHT  = 3'd4;
    localparam logic [KEY_BITS-1:0] KEY_DOWN   = 3'd5;

    localparam logic [EV_BITS-1:0] EV_NONE     = 2'd0;
    localparam logic [EV_BITS-1:0] EV_PRESSED  = 2'd1;
    localparam logic [EV_BITS-1:0] EV_RELEASED = 2'd2;

    localparam logic [CFG_ADDR_BITS-1:0] REG_UP_LOW         = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_LEFT_LOW       = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_CENTER_LOW     = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_RIGHT_LOW      = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_DOWN_LOW       = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] REG_DOWN_HIGH      = 3'd5;
    localparam logic [CFG_ADDR_BITS-1:0] REG_DEBOUNCE_COUNT = 3'd6;

    localparam logic [THR_BITS-1:0] UP_LOW_RST     = 12'd1500;
    localparam logic [THR_BITS-1:0] LEFT_LOW_RST   = 12'd2315;
    localparam logic [THR_BITS-1:0] CENTER_LOW_RST = 12'd2815;
    localparam logic [THR_BITS-1:0] RIGHT_LOW_RST  = 12'd3080;
    localparam logic [THR_BITS-1:0] DOWN_LOW_RST   = 12'd3240;
    localparam logic [THR_BITS-1:0] DOWN_HIGH_RST  = 12'd3649;
    localparam logic [CNT_BITS-1:0] DEBOUNCE_RST   = 4'd3;

    typedef struct packed {
        logic [THR_BITS-1:0] up_low;
        logic [THR_BITS-1:0] left_low;
        logic [THR_BITS-1:0] center_low;
        logic [THR_BITS-1:0] right_low;
        logic [THR_BITS-1:0] down_low;
        logic [THR_BITS-1:0] down_high;
        logic [CNT_BITS-1:0] debounce_count;
    } cfg_t;

    typedef struct packed {
        logic [EV_BITS-1:0]  key_event;
        logic [KEY_BITS-1:0] stable_key;
        logic [KEY_BITS-1:0] instant_key;
    } dbn_res_t;

endpackage

### hdl/ladk_regs.sv
module ladk_regs
    import ladk_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [THR_BITS-1:0]      cfg_wdata,
    output cfg_t                     cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                REG_UP_LOW:         cfg_next.up_low         = cfg_wdata;
                REG_LEFT_LOW:       cfg_next.left_low       = cfg_wdata;
                REG_CENTER_LOW:     cfg_next.center_low     = cfg_wdata;
                REG_RIGHT_LOW:      cfg_next.right_low      = cfg_wdata;
                REG_DOWN_LOW:       cfg_next.down_low       = cfg_wdata;
                REG_DOWN_HIGH:      cfg_next.down_high      = cfg_wdata;
                REG_DEBOUNCE_COUNT: cfg_next.debounce_count = cfg_wdata[CNT_BITS-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.up_low         <= UP_LOW_RST;
            cfg_reg.left_low       <= LEFT_LOW_RST;
            cfg_reg.center_low     <= CENTER_LOW_RST;
            cfg_reg.right_low      <= RIGHT_LOW_RST;
            cfg_reg.down_low       <= DOWN_LOW_RST;
            cfg_reg.down_high      <= DOWN_HIGH_RST;
            cfg_reg.debounce_count <= DEBOUNCE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### hdl/ladk_classify.sv
module ladk_classify
    import ladk_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic [SAMPLE_BITS-1:0] sample,
    input  cfg_t                   cfg,
    output logic [KEY_BITS-1:0]    key
);

    localparam int CMP_W = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;

    logic [CMP_W-1:0] s_ext;
    logic [CMP_W-1:0] up_lo;
    logic [CMP_W-1:0] left_lo;
    logic [CMP_W-1:0] center_lo;
    logic [CMP_W-1:0] right_lo;
    logic [CMP_W-1:0] down_lo;
    logic [CMP_W-1:0] down_hi;

    assign s_ext     = CMP_W'(sample);
    assign up_lo     = CMP_W'(cfg.up_low);
    assign left_lo   = CMP_W'(cfg.left_low);
    assign center_lo = CMP_W'(cfg.center_low);
    assign right_lo  = CMP_W'(cfg.right_low);
    assign down_lo   = CMP_W'(cfg.down_low);
    assign down_hi   = CMP_W'(cfg.down_high);

    // Windows span low bound to next bound - 1, down to down_high; first match wins.
    always_comb
    begin
        if (s_ext >= up_lo && s_ext < left_lo)
            key = KEY_UP;
        else if (s_ext >= left_lo && s_ext < center_lo)
            key = KEY_LEFT;
        else if (s_ext >= center_lo && s_ext < right_lo)
            key = KEY_CENTER;
        else if (s_ext >= right_lo && s_ext < down_lo)
            key = KEY_RIGHT;
        else if (s_ext >= down_lo && s_ext <= down_hi)
            key = KEY_DOWN;
        else
            key = KEY_NONE;
    end

endmodule

### hdl/ladk_debounce.sv
module ladk_debounce
    import ladk_pkg::*;
`include "ladder_key_decode_debounce_macros.svh"
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [KEY_BITS-1:0] key,
    input  logic [CNT_BITS-1:0] debounce_count,
    output dbn_res_t            res
);

    logic [KEY_BITS-1:0] cand_reg;
    logic [KEY_BITS-1:0] cand_next;
    logic [CNT_BITS-1:0] run_reg;
    logic [CNT_BITS-1:0] run_next;
    logic [KEY_BITS-1:0] deb_reg;
    logic [KEY_BITS-1:0] deb_next;
    logic [EV_BITS-1:0]  ev;

    always_comb
    begin
        cand_next = cand_reg;
        run_next  = run_reg;
        deb_next  = deb_reg;
        ev        = EV_NONE;
        if (key != cand_reg)
        begin
            // new candidate: restart the run, never an event
            cand_next = key;
            run_next  = {{(CNT_BITS-1){1'b0}}, 1'b1};
        end
        else
        begin
            if (run_reg < debounce_count)
                run_next = run_reg + 1'b1;
            if (run_next >= debounce_count && key != deb_reg)
            begin
                deb_next = key;
                ev       = (key == KEY_NONE) ? EV_RELEASED : EV_PRESSED;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_reg <= KEY_NONE;
            run_reg  <= '0;
            deb_reg  <= KEY_NONE;
        end
        else if (step)
        begin
            cand_reg <= cand_next;
            run_reg  <= run_next;
            deb_reg  <= deb_next;
        end
    end

    assign res.key_event   = ev;
    assign res.stable_key  = deb_next;
    assign res.instant_key = key;

    `LADK_ASSERT_NEXT(a_hold_state, !step,
        $stable(cand_reg) && $stable(run_reg) && $stable(deb_reg),
        "debounce state moved without a word")
    `LADK_ASSERT_NEXT(a_new_cand, step && key != cand_reg,
        run_reg == 1 && cand_reg == $past(key) && $stable(deb_reg),
        "candidate change did not restart the run")
    `LADK_ASSERT(a_event_change, ev == EV_NONE || (key == cand_reg && key != deb_reg),
        "event raised without a stable key change")

endmodule

### hdl/ladder_key_decode_debounce.sv
// Five-way resistor-ladder joystick decoder with debounce.
//
// Input stream (s_*): one converter sample per word in s_tdata. Each sample
// is sorted into none, up, left, center, right or down by the window
// registers, then filtered: the stable key changes once the same key has
// been seen debounce_count times in a row (and at least twice).
// Output stream (m_*): one word per input word carrying the event (none,
// pressed, released), the stable key after this sample and the raw key.
// Configuration: cfg_we writes cfg_wdata to the register at cfg_addr
// (0..6: window bounds, then debounce count); other indexes are ignored.
// Write only while no word is in flight.
//
// The input register feeds classify and debounce into the output register. One
// word is taken every cycle unless the receiver stalls; both stages advance
// together whenever the output register is empty or being taken, so a stalled
// receiver holds the output and the input stage and backs up s_tready after
// one more word.
// Reset clears the pipeline, the debounce state (no key) and loads the
// default window bounds and count.
module ladder_key_decode_debounce
    import ladk_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_tdata,   // adc_sample
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [7:0]                           m_tdata,   // key_event, stable_key, instant_key
    input  logic                                 cfg_we,
    input  logic [CFG_ADDR_BITS-1:0]             cfg_addr,
    input  logic [THR_BITS-1:0]                  cfg_wdata
);

    cfg_t                   cfg;
    logic                   in_valid_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic                   out_valid_reg;
    dbn_res_t               res;
    dbn_res_t               res_reg;
    logic [KEY_BITS-1:0]    key;
    logic                   adv;
    logic                   step;

    assign adv      = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && adv;
    assign s_tready = !in_valid_reg || adv;

    ladk_regs u_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ladk_classify #(.SAMPLE_BITS(SAMPLE_BITS)) u_classify
    (
        .sample (sample_reg),
        .cfg    (cfg),
        .key    (key)
    );

    ladk_debounce u_debounce
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .key            (key),
        .debounce_count (cfg.debounce_count),
        .res            (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (adv)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            sample_reg <= s_tdata[SAMPLE_BITS-1:0];
        if (step)
            res_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {res_reg.instant_key, res_reg.stable_key, res_reg.key_event};

endmodule

### sim/tb_ladder_key_decode_debounce.sv
module tb_ladder_key_decode_debounce;
    import ladk_pkg::*;

    localparam logic [CFG_ADDR_BITS-1:0] REG_UNUSED = 3'd7;
    localparam int                       STALL_LIMIT = 2000;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [15:0]              s_tdata = '0;   // adc_sample
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [7:0]               m_tdata;        // key_event, stable_key, instant_key
    logic                     cfg_we = 1'b0;
    logic [CFG_ADDR_BITS-1:0] cfg_addr = '0;
    logic [THR_BITS-1:0]      cfg_wdata = '0;

    // words waiting to be sent, and the decoded words expected back
    logic [THR_BITS-1:0] sample_q[$];
    dbn_res_t            key_word_q[$];

    // shadow of the block's registers and debounce state
    cfg_t                shadow;
    logic [KEY_BITS-1:0] cand_key;
    logic [CNT_BITS-1:0] run_len;
    logic [KEY_BITS-1:0] held_key;

    int  errors = 0;
    int  idle_cycles = 0;
    int  send_gap = 0;
    int  recv_stall = 0;
    bit  send_busy = 0;
    bit  send_burst = 0;
    bit  recv_burst = 0;

    ladder_key_decode_debounce dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [KEY_BITS-1:0] window_key(logic [THR_BITS-1:0] s);
        if (s >= shadow.up_low && s < shadow.left_low)
            return KEY_UP;
        if (s >= shadow.left_low && s < shadow.center_low)
            return KEY_LEFT;
        if (s >= shadow.center_low && s < shadow.right_low)
            return KEY_CENTER;
        if (s >= shadow.right_low && s < shadow.down_low)
            return KEY_RIGHT;
        if (s >= shadow.down_low && s <= shadow.down_high)
            return KEY_DOWN;
        return KEY_NONE;
    endfunction

    function void predict_key_word(logic [THR_BITS-1:0] s);
        dbn_res_t            w;
        logic [KEY_BITS-1:0] k;
        k = window_key(s);
        w.key_event = EV_NONE;
        if (k != cand_key)
        begin
            cand_key = k;
            run_len = 4'd1;
        end
        else
        begin
            if (run_len < shadow.debounce_count)
                run_len = run_len + 4'd1;
            if (run_len >= shadow.debounce_count && k != held_key)
            begin
                held_key = k;
                w.key_event = (k == KEY_NONE) ? EV_RELEASED : EV_PRESSED;
            end
        end
        w.stable_key = held_key;
        w.instant_key = k;
        key_word_q.push_back(w);
    endfunction

    // gap before the next word; bursts flip now and then to give stretches without gaps
    function automatic int draw_wait(ref bit burst);
        if ($urandom_range(0, 29) == 0)
            burst = !burst;
        return burst ? 0 : $urandom_range(0, 19);
    endfunction

    function automatic logic [THR_BITS-1:0] pick_sample(logic [KEY_BITS-1:0] key);
        int lo;
        int hi;
        lo = 0;
        hi = -1;
        case (key)
            KEY_UP:     begin lo = int'(shadow.up_low);     hi = int'(shadow.left_low) - 1;   end
            KEY_LEFT:   begin lo = int'(shadow.left_low);   hi = int'(shadow.center_low) - 1; end
            KEY_CENTER: begin lo = int'(shadow.center_low); hi = int'(shadow.right_low) - 1;  end
            KEY_RIGHT:  begin lo = int'(shadow.right_low);  hi = int'(shadow.down_low) - 1;   end
            KEY_DOWN:   begin lo = int'(shadow.down_low);   hi = int'(shadow.down_high);      end
            default:
            begin
                // aim outside the whole ladder: below up or above down
                if (shadow.up_low > 0)
                    hi = int'(shadow.up_low) - 1;
                else if (shadow.down_high < 12'hFFF)
                begin
                    lo = int'(shadow.down_high) + 1;
                    hi = 4095;
                end
            end
        endcase
        if (hi < lo)
            return THR_BITS'($urandom_range(0, 4095));
        return THR_BITS'($urandom_range(hi, lo));
    endfunction

    task automatic report_mismatch(string what, int want, int got);
        $display("mismatch on %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
        errors++;
    endtask

    task automatic write_reg(logic [CFG_ADDR_BITS-1:0] idx, logic [THR_BITS-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= data;
        case (idx)
            REG_UP_LOW:         shadow.up_low = data;
            REG_LEFT_LOW:       shadow.left_low = data;
            REG_CENTER_LOW:     shadow.center_low = data;
            REG_RIGHT_LOW:      shadow.right_low = data;
            REG_DOWN_LOW:       shadow.down_low = data;
            REG_DOWN_HIGH:      shadow.down_high = data;
            REG_DEBOUNCE_COUNT: shadow.debounce_count = data[CNT_BITS-1:0];
            default:            ;
        endcase
    endtask

    task automatic load_setting(cfg_t c);
        write_reg(REG_UP_LOW, c.up_low);
        write_reg(REG_LEFT_LOW, c.left_low);
        write_reg(REG_CENTER_LOW, c.center_low);
        write_reg(REG_RIGHT_LOW, c.right_low);
        write_reg(REG_DOWN_LOW, c.down_low);
        write_reg(REG_DOWN_HIGH, c.down_high);
        // upper bits of the count write are junk and must be dropped
        write_reg(REG_DEBOUNCE_COUNT, {8'($urandom), c.debounce_count});
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // sample at the falling edge so the clocked blocks have settled
    task automatic wait_drained();
        do
            @(negedge clk);
        while (sample_q.size() != 0 || s_tvalid || key_word_q.size() != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic queue_random(int n);
        int                  sent;
        int                  len;
        logic [KEY_BITS-1:0] key;
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                // a run of one key, of random length up to debounce_count + 3, with the odd glitch
                key = KEY_BITS'($urandom_range(0, int'(KEY_DOWN)));
                len = $urandom_range(1, int'(shadow.debounce_count) + 3);
                repeat (len)
                begin
                    if ($urandom_range(0, 7) == 0)
                        sample_q.push_back(THR_BITS'($urandom_range(0, 4095)));
                    else
                        sample_q.push_back(pick_sample(key));
                    sent++;
                end
            end
            else
            begin
                sample_q.push_back(THR_BITS'($urandom_range(0, 4095)));
                sent++;
            end
        end
    endtask

    // driver: one pending sample at a time, random gap between words
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            send_busy = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_key_word(s_tdata[THR_BITS-1:0]);
                send_busy = 0;
                send_gap = draw_wait(send_burst);
            end
            if (!send_busy)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (sample_q.size() > 0)
                begin
                    s_tdata <= {4'b0, sample_q.pop_front()};
                    send_busy = 1;
                end
            end
            s_tvalid <= send_busy;
        end
    end

    // monitor: compare each decoded word with the oldest expectation
    always @(posedge clk)
    begin
        dbn_res_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (key_word_q.size() == 0)
                    report_mismatch("unexpected word", 0, int'(m_tdata));
                else
                begin
                    want = key_word_q.pop_front();
                    if (m_tdata[1:0] != want.key_event)
                        report_mismatch("key_event", want.key_event, m_tdata[1:0]);
                    if (m_tdata[4:2] != want.stable_key)
                        report_mismatch("stable_key", want.stable_key, m_tdata[4:2]);
                    if (m_tdata[7:5] != want.instant_key)
                        report_mismatch("instant_key", want.instant_key, m_tdata[7:5]);
                end
                recv_stall = draw_wait(recv_burst);
            end
            else if (recv_stall > 0)
                recv_stall--;
            m_tready <= (recv_stall == 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles == STALL_LIMIT)
            begin
                $display("ladder_key_decode_debounce test failed");
                $finish;
            end
        end
    end

    initial
    begin
        cfg_t                c;
        logic [THR_BITS-1:0] b[6];
        logic [THR_BITS-1:0] t;
        logic [THR_BITS-1:0] directed[$];

        shadow = '{UP_LOW_RST, LEFT_LOW_RST, CENTER_LOW_RST, RIGHT_LOW_RST,
                   DOWN_LOW_RST, DOWN_HIGH_RST, DEBOUNCE_RST};
        cand_key = KEY_NONE;
        run_len = '0;
        held_key = KEY_NONE;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // window edges at the reset bounds, with runs long enough to press and release
        directed = '{12'd0, 12'd0, 12'd0, 12'd1500, 12'd1500, 12'd1500, 12'd2314,
                     12'd2315, 12'd2315, 12'd2315, 12'd4095, 12'd4095, 12'd4095,
                     12'd3649, 12'd3649, 12'd3649, 12'd3650, 12'd1499, 12'd2814,
                     12'd2815, 12'd3079, 12'd3080, 12'd3239, 12'd3240, 12'd4095};
        foreach (directed[i])
            sample_q.push_back(directed[i]);
        wait_drained();

        // count of one: press on the second equal sample
        c = '{UP_LOW_RST, LEFT_LOW_RST, CENTER_LOW_RST, RIGHT_LOW_RST,
              DOWN_LOW_RST, DOWN_HIGH_RST, 4'd1};
        load_setting(c);
        queue_random(100);
        wait_drained();

        // count of zero, plus a write to an index that does not exist
        c.debounce_count = 4'd0;
        load_setting(c);
        write_reg(REG_UNUSED, THR_BITS'($urandom));
        @(posedge clk);
        cfg_we <= 1'b0;
        queue_random(90);
        wait_drained();

        // all lower bounds at zero: only down matches, across the whole range
        c = '{12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'hFFF, 4'd15};
        load_setting(c);
        queue_random(60);
        wait_drained();

        // overlapping windows and an inverted down window
        c = '{12'd0, 12'd4000, 12'd100, 12'd3000, 12'd3500, 12'd200, 4'd2};
        load_setting(c);
        queue_random(90);
        wait_drained();

        repeat (3)
        begin
            foreach (b[i])
                b[i] = THR_BITS'($urandom);
            for (int i = 0; i < 6; i++)
                for (int j = 0; j < 5 - i; j++)
                    if (b[j] > b[j+1])
                    begin
                        t = b[j];
                        b[j] = b[j+1];
                        b[j+1] = t;
                    end
            c = '{b[0], b[1], b[2], b[3], b[4], b[5], CNT_BITS'($urandom_range(1, 15))};
            load_setting(c);
            queue_random(90);
            wait_drained();
        end

        // narrow windows pushed to both ends of the range
        c = '{12'd0, 12'd1, 12'd2, 12'hFFE, 12'hFFF, 12'hFFF, 4'd15};
        load_setting(c);
        queue_random(80);
        wait_drained();

        repeat (10) @(posedge clk);
        if (errors == 0 && key_word_q.size() == 0)
            $display("ladder_key_decode_debounce test passed");
        else
            $display("ladder_key_decode_debounce test failed");
        $finish;
    end

endmodule
